/* rtl/core/dssr_pkg.sv */
// Shared types and constants for the dual servo speed ramp.
// Holds the configuration register struct, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package dssr_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIndexW = 3;
  localparam logic [CfgIndexW-1:0] CFG_STEP_SIZE     = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_RAMP_INTERVAL = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_SPEED_MIN     = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_SPEED_MAX     = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_DEADBAND_LOW  = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_DEADBAND_HIGH = 3'd5;
  localparam logic [CfgIndexW-1:0] CFG_NEUTRAL       = 3'd6;

  localparam int unsigned CfgDataW = 16;

  // Reset values
  localparam logic [4:0]  STEP_SIZE_RST     = 5'd5;
  localparam logic [15:0] RAMP_INTERVAL_RST = 16'd20;
  localparam logic [7:0]  SPEED_MIN_RST     = 8'd15;
  localparam logic [7:0]  SPEED_MAX_RST     = 8'd165;
  localparam logic [7:0]  DEADBAND_LOW_RST  = 8'd80;
  localparam logic [7:0]  DEADBAND_HIGH_RST = 8'd100;
  localparam logic [7:0]  NEUTRAL_RST       = 8'd90;
  localparam logic [7:0]  SPEED_RST         = 8'd90;

  // Live configuration as seen by the channel logic
  typedef struct packed {
    logic [4:0]  step_size;
    logic [15:0] ramp_interval_ms;
    logic [7:0]  speed_min;
    logic [7:0]  speed_max;
    logic [7:0]  deadband_low;
    logic [7:0]  deadband_high;
    logic [7:0]  neutral;
  } cfg_t;

endpackage

/* rtl/core/dssr_channel.sv */
// One servo channel: near-target test, one ramp step with clamping, deadband mapping.
// Pure combinational; depends on dssr_pkg for cfg_t.
`timescale 1ns / 1ps

module dssr_channel
  import dssr_pkg::*;
(
  input  logic [7:0] cur,
  input  logic [7:0] target,
  input  cfg_t       cfg,
  input  logic       step_en,
  output logic       near,
  output logic [7:0] speed_next,
  output logic [7:0] drive
);

  logic [7:0]        diff_abs;
  logic [8:0]        sum;
  logic signed [9:0] v_ramp;
  logic signed [9:0] v_hi;
  logic signed [9:0] v_lo;

  // Within one of target
  assign diff_abs = (cur > target) ? (cur - target) : (target - cur);
  assign near     = (diff_abs[7:1] == 7'd0);

  assign sum = {1'b0, cur} + {4'b0, cfg.step_size};

  // Step toward target; an overshooting add is undone
  always_comb begin
    if (cur < target) begin
      v_ramp = (sum > {1'b0, target}) ? $signed({2'b00, cur}) : $signed({1'b0, sum});
    end else if (cur > target) begin
      v_ramp = $signed({2'b00, cur}) - $signed({5'b0, cfg.step_size});
    end else begin
      v_ramp = $signed({2'b00, cur});
    end
  end

  // Clamp to max first, then min (inverted limits end at min)
  always_comb begin
    v_hi = (v_ramp > $signed({2'b00, cfg.speed_max})) ? $signed({2'b00, cfg.speed_max})
                                                       : v_ramp;
    v_lo = (v_hi < $signed({2'b00, cfg.speed_min})) ? $signed({2'b00, cfg.speed_min})
                                                     : v_hi;
  end

  assign speed_next = step_en ? v_lo[7:0] : cur;

  // Deadband: inside the band, other than neutral itself, drive neutral
  assign drive = (speed_next <= cfg.deadband_low || speed_next >= cfg.deadband_high ||
                  speed_next == cfg.neutral) ? speed_next : cfg.neutral;

endmodule

/* rtl/core/dual_servo_speed_ramp.sv */
// Top level of the dual servo speed ramp (slew-rate limiter).
// Depends on dssr_pkg and dssr_channel.
//
// Channel   Dir  Signals                              Payload
// s_axis    in   s_tvalid s_tready s_tdata[47:0]     target_left, target_right, time_ms
// m_axis    out  m_tvalid m_tready m_tdata[23:0]     drive_left, drive_right, stepped, at_target
// cfg       in   cfg_valid cfg_ready cfg_index cfg_data  register index, write value
//
// One item per cycle while the output is not stalled; each passes the input register, then the result register.
// Stored speeds and last step time update on the edge that loads the result register,
// so the next item in the input register sees them directly.
// rst (synchronous) restores registers, speeds (90) and last step time (0).
// An output stall holds the result; the input register takes one more item, then stalls.
`timescale 1ns / 1ps

module dual_servo_speed_ramp
  import dssr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [47:0]          s_tdata,   // target_left[7:0], target_right[15:8], time_ms[47:16]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // drive_left[7:0], drive_right[15:8], stepped[16],
                                          // at_target[17], zero[23:18]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  cfg_t        cfg;
  logic        in_valid;
  logic [7:0]  in_tl;
  logic [7:0]  in_tr;
  logic [31:0] in_time;
  logic        advance;

  logic [7:0]  left_speed;
  logic [7:0]  right_speed;
  logic [31:0] last_step_time;

  logic        near_l;
  logic        near_r;
  logic        at;
  logic        step;
  logic [31:0] elapsed;
  logic [7:0]  left_speed_next;
  logic [7:0]  right_speed_next;
  logic [7:0]  drive_l;
  logic [7:0]  drive_r;

  logic        out_valid;
  logic [7:0]  out_drive_l;
  logic [7:0]  out_drive_r;
  logic        out_stepped;
  logic        out_at;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_size        <= STEP_SIZE_RST;
      cfg.ramp_interval_ms <= RAMP_INTERVAL_RST;
      cfg.speed_min        <= SPEED_MIN_RST;
      cfg.speed_max        <= SPEED_MAX_RST;
      cfg.deadband_low     <= DEADBAND_LOW_RST;
      cfg.deadband_high    <= DEADBAND_HIGH_RST;
      cfg.neutral          <= NEUTRAL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STEP_SIZE:     cfg.step_size        <= cfg_data[4:0];
        CFG_RAMP_INTERVAL: cfg.ramp_interval_ms <= cfg_data;
        CFG_SPEED_MIN:     cfg.speed_min        <= cfg_data[7:0];
        CFG_SPEED_MAX:     cfg.speed_max        <= cfg_data[7:0];
        CFG_DEADBAND_LOW:  cfg.deadband_low     <= cfg_data[7:0];
        CFG_DEADBAND_HIGH: cfg.deadband_high    <= cfg_data[7:0];
        CFG_NEUTRAL:       cfg.neutral          <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result register is free
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_tl   <= s_tdata[7:0];
      in_tr   <= s_tdata[15:8];
      in_time <= s_tdata[47:16];
    end
  end

  // Step decision shared by both channels
  assign at      = near_l || near_r;
  assign elapsed = in_time - last_step_time;
  assign step    = (elapsed > {16'd0, cfg.ramp_interval_ms}) && !at;

  dssr_channel u_left (
    .cur        (left_speed),
    .target     (in_tl),
    .cfg        (cfg),
    .step_en    (step),
    .near       (near_l),
    .speed_next (left_speed_next),
    .drive      (drive_l)
  );

  dssr_channel u_right (
    .cur        (right_speed),
    .target     (in_tr),
    .cfg        (cfg),
    .step_en    (step),
    .near       (near_r),
    .speed_next (right_speed_next),
    .drive      (drive_r)
  );

  // Ramp state
  always_ff @(posedge clk) begin
    if (rst) begin
      left_speed     <= SPEED_RST;
      right_speed    <= SPEED_RST;
      last_step_time <= 32'd0;
    end else if (advance && step) begin
      left_speed     <= left_speed_next;
      right_speed    <= right_speed_next;
      last_step_time <= in_time;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drive_l <= drive_l;
      out_drive_r <= drive_r;
      out_stepped <= step;
      out_at      <= at;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_at, out_stepped, out_drive_r, out_drive_l};

endmodule

/* test/dssr_checker.sv */
// Result checker for the dual servo speed ramp: watches the cfg, input and result channels.
// Keeps its own copy of the ramp state, predicts each result and compares it field by field.
// Depends on dssr_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module dssr_checker
  import dssr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [47:0]          s_tdata,   // target_left[7:0], target_right[15:8], time_ms[47:16]
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [23:0]          m_tdata,   // drive_left[7:0], drive_right[15:8], stepped[16],
                                          // at_target[17], zero[23:18]
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output int                   mismatches,
  output int                   pending
);

  // One result item, drive_left in the lowest bits
  typedef struct packed {
    logic       at_target;
    logic       stepped;
    logic [7:0] drive_right;
    logic [7:0] drive_left;
  } drive_result_t;

  cfg_t          live_cfg;
  logic [7:0]    left_spd;
  logic [7:0]    right_spd;
  logic [31:0]   last_step_ms;
  drive_result_t expected_drives[$];
  int            err_count = 0;

  // Move one stored speed toward its target by one step, then clamp (max first, min last)
  function automatic logic [7:0] ramp_toward(logic [7:0] cur, logic [7:0] tgt);
    int v;
    int t;
    int s;
    v = cur;
    t = tgt;
    s = live_cfg.step_size;
    if (v < t) begin
      v += s;
      if (v > t) v -= s;  // overshoot: back out the step
    end else if (v > t) begin
      v -= s;
    end
    if (v > int'(live_cfg.speed_max)) v = live_cfg.speed_max;
    if (v < int'(live_cfg.speed_min)) v = live_cfg.speed_min;
    return v[7:0];
  endfunction

  // Speeds strictly inside the deadband drive as neutral
  function automatic logic [7:0] deadband_map(logic [7:0] spd);
    if (spd <= live_cfg.deadband_low || spd >= live_cfg.deadband_high ||
        spd == live_cfg.neutral)
      return spd;
    return live_cfg.neutral;
  endfunction

  function automatic logic within_one(logic [7:0] a, logic [7:0] b);
    return ((a > b) ? (a - b) : (b - a)) < 8'd2;
  endfunction

  always @(posedge clk) begin
    drive_result_t got;
    drive_result_t want;
    logic [7:0]    tl;
    logic [7:0]    tr;
    logic [31:0]   now_ms;
    logic [31:0]   elapsed;
    logic          near_any;
    logic          took_step;
    if (rst) begin
      live_cfg.step_size        = STEP_SIZE_RST;
      live_cfg.ramp_interval_ms = RAMP_INTERVAL_RST;
      live_cfg.speed_min        = SPEED_MIN_RST;
      live_cfg.speed_max        = SPEED_MAX_RST;
      live_cfg.deadband_low     = DEADBAND_LOW_RST;
      live_cfg.deadband_high    = DEADBAND_HIGH_RST;
      live_cfg.neutral          = NEUTRAL_RST;
      left_spd     = SPEED_RST;
      right_spd    = SPEED_RST;
      last_step_ms = '0;
      expected_drives.delete();
    end else begin
      // Register writes; unknown indexes are ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STEP_SIZE:     live_cfg.step_size        = cfg_data[4:0];
          CFG_RAMP_INTERVAL: live_cfg.ramp_interval_ms = cfg_data[15:0];
          CFG_SPEED_MIN:     live_cfg.speed_min        = cfg_data[7:0];
          CFG_SPEED_MAX:     live_cfg.speed_max        = cfg_data[7:0];
          CFG_DEADBAND_LOW:  live_cfg.deadband_low     = cfg_data[7:0];
          CFG_DEADBAND_HIGH: live_cfg.deadband_high    = cfg_data[7:0];
          CFG_NEUTRAL:       live_cfg.neutral          = cfg_data[7:0];
          default: ;
        endcase
      end

      // Result side: compare against the oldest prediction
      if (m_tvalid && m_tready) begin
        got = m_tdata[17:0];
        if (expected_drives.size() == 0) begin
          if (err_count < 10)
            $display("%t unexpected result: drive_left=%0d drive_right=%0d stepped=%0b at_target=%0b",
                     $realtime, got.drive_left, got.drive_right, got.stepped, got.at_target);
          err_count++;
        end else begin
          want = expected_drives.pop_front();
          if (got.drive_left != want.drive_left || got.drive_right != want.drive_right ||
              got.stepped != want.stepped || got.at_target != want.at_target) begin
            if (err_count < 10)
              $display("%t mismatch: expected L=%0d R=%0d stepped=%0b at_target=%0b, got L=%0d R=%0d stepped=%0b at_target=%0b",
                       $realtime, want.drive_left, want.drive_right, want.stepped,
                       want.at_target, got.drive_left, got.drive_right, got.stepped,
                       got.at_target);
            err_count++;
          end
        end
      end

      // Input side: advance the ramp state and queue the result
      if (s_tvalid && s_tready) begin
        tl      = s_tdata[7:0];
        tr      = s_tdata[15:8];
        now_ms  = s_tdata[47:16];
        elapsed = now_ms - last_step_ms;  // wraps modulo 2^32
        // either channel near its target holds both (OR)
        near_any  = within_one(left_spd, tl) || within_one(right_spd, tr);
        took_step = 1'b0;
        if (elapsed > 32'(live_cfg.ramp_interval_ms) && !near_any) begin
          left_spd     = ramp_toward(left_spd, tl);
          right_spd    = ramp_toward(right_spd, tr);
          last_step_ms = now_ms;
          took_step    = 1'b1;
        end
        want.drive_left  = deadband_map(left_spd);
        want.drive_right = deadband_map(right_spd);
        want.stepped     = took_step;
        want.at_target   = near_any;
        expected_drives.push_back(want);
      end
    end
    pending    <= expected_drives.size();
    mismatches <= err_count;
  end

endmodule

/* test/testbench.sv */
// Top of the dual servo speed ramp test: clock, reset, cfg writes, target items, idling.
// Instantiates dual_servo_speed_ramp and dssr_checker; gives the verdict.
// Depends on dssr_pkg, the RTL and test/dssr_checker.sv.
`timescale 1ns / 1ps

module testbench;
  import dssr_pkg::*;

  localparam int ItemsPerPhase = 160;
  localparam int Phases        = 8;
  localparam int HoldCycles    = 300;
  localparam logic [CfgIndexW-1:0] CFG_UNUSED = 3'd7;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [47:0]          s_tdata   = '0;   // target_left[7:0], target_right[15:8], time_ms[47:16]
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [23:0]          m_tdata;          // drive_left[7:0], drive_right[15:8], stepped[16],
                                          // at_target[17], zero[23:18]
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  int          mismatches;
  int          pending;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_reqs      = 0;
  int          hold_taken     = 0;
  int          hold_left      = 0;
  logic [31:0] clock_ms       = '0;
  logic [15:0] interval_ms    = RAMP_INTERVAL_RST;
  logic [7:0]  aim_left       = 8'd90;
  logic [7:0]  aim_right      = 8'd90;

  always #5 clk = ~clk;

  dual_servo_speed_ramp dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dssr_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_reqs != hold_taken) begin
      hold_taken <= hold_reqs;
      hold_left  <= HoldCycles;
      m_tready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one item after a random gap; returns at the falling edge after acceptance
  task automatic send_item(input logic [7:0] tl, input logic [7:0] tr, input logic [31:0] t);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {t, tr, tl};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Ramping targets held for a while, clock steps around the interval, some noise
  task automatic send_ramp_item();
    int r;
    r = $urandom_range(99);
    if (r < 4) begin
      aim_left  = 8'($urandom_range(255));
      aim_right = 8'($urandom_range(255));
    end else if (r < 14) begin
      aim_left  = 8'($urandom_range(180));
      aim_right = 8'($urandom_range(180));
    end else if (r < 18) begin
      aim_right = 8'($urandom_range(180));
    end
    r = $urandom_range(99);
    if (r < 3)       clock_ms = $urandom();
    else if (r < 20) clock_ms = clock_ms + interval_ms;
    else if (r < 40) clock_ms = clock_ms + interval_ms + 1;
    else             clock_ms = clock_ms + $urandom_range(2 * interval_ms + 2);
    send_item(aim_left, aim_right, clock_ms);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [15:0] step;
    logic [15:0] intv;
    logic [15:0] vmin;
    logic [15:0] vmax;
    logic [15:0] dbl;
    logic [15:0] dbh;
    logic [15:0] neu;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset settings, speeds start at 90
    send_item(8'd0, 8'd180, 32'd0);           // no time elapsed
    send_item(8'd0, 8'd180, 32'd20);          // exactly the interval: no step
    send_item(8'd0, 8'd180, 32'd21);          // first step, both land in deadband
    clock_ms = 32'd21;
    for (int k = 0; k < 13; k++) begin        // ramp both channels toward their targets
      clock_ms = clock_ms + 21;
      send_item(8'd0, 8'd180, clock_ms);
    end
    clock_ms = clock_ms + 30;
    send_item(8'd16, 8'd0, clock_ms);         // right reverses toward 0, left steps on toward 16
    clock_ms = clock_ms + 30;
    send_item(8'd255, 8'd255, clock_ms);      // top of field; both channels step up toward it
    clock_ms = clock_ms + 30;
    send_item(8'd23, 8'd0, clock_ms);         // left overshoot, step backed out
    send_item(8'd180, 8'd0, 32'hFFFF_FFF0);
    send_item(8'd180, 8'd0, 32'd5);           // wrapped elapsed time
    send_item(8'd0, 8'd180, 32'hFFFF_FFFF);
    clock_ms = 32'hFFFF_FFFF;

    for (int p = 1; p <= Phases; p++) begin
      s_tvalid <= 1'b0;
      wait_idle();
      case (p)
        1: begin
          step = 5;  intv = 20;    vmin = 15;  vmax = 165; dbl = 80;  dbh = 100; neu = 90;
        end
        2: begin
          step = 31; intv = 0;     vmin = 0;   vmax = 180; dbl = 0;   dbh = 180; neu = 90;
        end
        3: begin
          step = 1;  intv = 65535; vmin = 180; vmax = 0;   dbl = 180; dbh = 0;   neu = 0;
        end
        4: begin
          step = 0;  intv = 3;     vmin = 15;  vmax = 165; dbl = 80;  dbh = 100; neu = 180;
        end
        5, 8: begin
          step = 16'($urandom_range(31, 1));
          intv = 16'($urandom_range(64));
          vmin = 16'($urandom_range(60));
          vmax = 16'($urandom_range(180, 120));
          dbl  = 16'($urandom_range(100, 60));
          dbh  = 16'($urandom_range(130, 90));
          neu  = 16'($urandom_range(180));
        end
        6: begin
          // raw register noise, upper bits dropped by the block
          step = 16'($urandom()); intv = 16'($urandom_range(200));
          vmin = 16'($urandom()); vmax = 16'($urandom());
          dbl = 16'($urandom()); dbh = 16'($urandom()); neu = 16'($urandom());
          intv[15:8] = 8'($urandom());
        end
        default: begin
          step = 2; intv = 10; vmin = 50; vmax = 130; dbl = 85; dbh = 95; neu = 88;
        end
      endcase
      write_reg(CFG_STEP_SIZE, step);
      write_reg(CFG_RAMP_INTERVAL, intv);
      write_reg(CFG_SPEED_MIN, vmin);
      write_reg(CFG_SPEED_MAX, vmax);
      write_reg(CFG_DEADBAND_LOW, dbl);
      write_reg(CFG_DEADBAND_HIGH, dbh);
      write_reg(CFG_NEUTRAL, neu);
      if (p == 1) write_reg(CFG_UNUSED, 16'($urandom()));
      cfg_valid   <= 1'b0;
      interval_ms  = intv;
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (p == 4 && i == 20) hold_reqs++;   // back-pressure while input keeps coming
        send_ramp_item();
      end
    end

    s_tvalid <= 1'b0;
    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
